FILE: hdl/cdf_pkg.sv
// ----------------------------------------------------------------------------
// cdf_pkg
// Shared types, constants and the byte-wide CRC-32 update for the deframer.
// ----------------------------------------------------------------------------
package cdf_pkg;

   // sizes
   localparam int unsigned PAYLOAD_LIMIT = 512;
   localparam logic [15:0] PAYLOAD_LIMIT_W = 16'(PAYLOAD_LIMIT);
   localparam logic [10:0] POS_MAX = 11'h7FF;
   localparam int unsigned QUEUE_DEPTH = 3;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 10;

   // crc
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
   localparam logic [7:0] TR_CLEAR_MASK = 8'hDF;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CFG_DATA_TYPE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CFG_ACK_TYPE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CFG_NACK_TYPE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CFG_MAX_WINDOW = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CFG_MAX_PAYLOAD = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NO_HEADER = 3'd1;
   localparam logic [2:0] ST_SHORT = 3'd2;
   localparam logic [2:0] ST_BAD_TYPE = 3'd3;
   localparam logic [2:0] ST_BAD_WINDOW = 3'd4;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd5;
   localparam logic [2:0] ST_CRC_ERROR = 3'd6;

   typedef struct packed {
      logic [1:0] data_type_code;
      logic [1:0] ack_type_code;
      logic [1:0] nack_type_code;
      logic [4:0] max_window;
      logic [9:0] max_payload;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_datagram;
   } item_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [2:0]  status;
      logic [1:0]  packet_type;
      logic        truncated_flag;
      logic [4:0]  window_size;
      logic [9:0]  decoded_length;
      logic [7:0]  sequence_number;
      logic [31:0] time_stamp;
      logic [31:0] header_checksum;
   } result_type;

   // reflected crc-32, one byte
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

FILE: hdl/cdf_if.sv
// ----------------------------------------------------------------------------
// cdf_if
// Valid/ready channels of the deframer: byte input, result output, csr write.
// ----------------------------------------------------------------------------
interface cdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_datagram;

   modport source (output valid, output data_byte, output end_of_datagram, input ready);
   modport sink (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

interface cdf_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  payload_byte;
   logic [2:0]  status;
   logic [1:0]  packet_type;
   logic        truncated_flag;
   logic [4:0]  window_size;
   logic [9:0]  decoded_length;
   logic [7:0]  sequence_number;
   logic [31:0] time_stamp;
   logic [31:0] header_checksum;

   modport source (output valid, output kind, output payload_byte, output status,
                   output packet_type, output truncated_flag, output window_size,
                   output decoded_length, output sequence_number, output time_stamp,
                   output header_checksum, input ready);
   modport sink (input valid, input kind, input payload_byte, input status,
                 input packet_type, input truncated_flag, input window_size,
                 input decoded_length, input sequence_number, input time_stamp,
                 input header_checksum, output ready);
endinterface

interface cdf_csr_if;
   import cdf_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/crc_checked_packet_deframer.sv
// ----------------------------------------------------------------------------
// crc_checked_packet_deframer
// Byte-stream datagram deframer with header and payload CRC-32 checks.
// ----------------------------------------------------------------------------
// One datagram byte is taken per cycle with no gaps needed between items or
// datagrams. While a byte sits in the input register the parser updates its
// header fields and the shared byte-wide CRC-32 unit, and any result is
// written into a three-entry result queue at the next edge; a result shows on
// rsp_ch when all results queued ahead of it have been taken. Payload bytes
// come out as kind 0 items while no error is recorded, and the last byte of a
// datagram yields one kind 1 summary. req_ch.ready drops only when the result
// queue is backed up. Configuration writes are taken every cycle and should
// only be made while no datagram is in progress. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module crc_checked_packet_deframer (
   input  logic      clock,
   input  logic      reset,
   cdf_req_if.sink   req_ch,
   cdf_rsp_if.source rsp_ch,
   cdf_csr_if.sink   csr_ch
);
   import cdf_pkg::*;

   cfg_type    cfg;
   item_type   item;
   result_type res;
   logic       accept;
   logic       in_valid;
   logic       res_valid;
   logic       req_ready;

   assign req_ch.ready = req_ready;
   assign accept = req_ch.valid && req_ready;
   assign item.data_byte = req_ch.data_byte;
   assign item.end_of_datagram = req_ch.end_of_datagram;

   cdf_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   cdf_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (item),
      .cfg       (cfg),
      .in_valid  (in_valid),
      .res_valid (res_valid),
      .res       (res)
   );

   cdf_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .push      (res_valid),
      .push_data (res),
      .req_ready (req_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

FILE: hdl/cdf_regs.sv
// ----------------------------------------------------------------------------
// cdf_regs
// Configuration registers written through the csr channel.
// ----------------------------------------------------------------------------
module cdf_regs (
   input  logic             clock,
   input  logic             reset,
   cdf_csr_if.sink          csr_ch,
   output cdf_pkg::cfg_type cfg
);
   import cdf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CFG_DATA_TYPE:   cfg_in.data_type_code = csr_ch.data[1:0];
            CFG_ACK_TYPE:    cfg_in.ack_type_code = csr_ch.data[1:0];
            CFG_NACK_TYPE:   cfg_in.nack_type_code = csr_ch.data[1:0];
            CFG_MAX_WINDOW:  cfg_in.max_window = csr_ch.data[4:0];
            CFG_MAX_PAYLOAD: cfg_in.max_payload = csr_ch.data[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_type_code <= 2'd1;
         cfg_ff.ack_type_code <= 2'd2;
         cfg_ff.nack_type_code <= 2'd3;
         cfg_ff.max_window <= 5'd31;
         cfg_ff.max_payload <= 10'd512;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/cdf_parse.sv
// ----------------------------------------------------------------------------
// cdf_parse
// Input register and per-byte datagram parser with header and payload CRC.
// ----------------------------------------------------------------------------
module cdf_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  cdf_pkg::item_type   item,
   input  cdf_pkg::cfg_type    cfg,
   output logic                in_valid,
   output logic                res_valid,
   output cdf_pkg::result_type res
);
   import cdf_pkg::*;

   logic        in_valid_ff;
   item_type    in_item_ff;

   logic [10:0] pos_ff, pos_in;
   logic [7:0]  fhb_ff, fhb_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  seq_ff, seq_in;
   logic [31:0] stamp_ff, stamp_in;
   logic [31:0] run_ff, run_in;
   logic [31:0] hdr_ff, hdr_in;
   logic [31:0] rcv_ff, rcv_in;
   logic [2:0]  err_ff, err_in;

   logic        fwd;

   assign in_valid = in_valid_ff;

   always_comb begin
      logic [7:0]  byte_v;
      logic        eod_v;
      logic [1:0]  pkt_type;
      logic        tr;
      logic [4:0]  win;
      logic        is_data;
      logic [10:0] hend;
      logic [10:0] q;
      logic [15:0] len;
      logic [16:0] len_ext;
      logic [16:0] q_ext;
      logic [1:0]  idx;
      logic [7:0]  crc_src;
      logic [31:0] crc_step;
      logic [11:0] n;
      logic [16:0] needed;
      logic [2:0]  st;
      logic [9:0]  plen;

      byte_v = in_item_ff.data_byte;
      eod_v = in_item_ff.end_of_datagram;

      fhb_in = (pos_ff == 11'd0) ? byte_v : fhb_ff;
      pkt_type = fhb_in[7:6];
      tr = fhb_in[5];
      win = fhb_in[4:0];
      is_data = (pkt_type == cfg.data_type_code);
      hend = is_data ? 11'd8 : 11'd6;

      err_in = err_ff;
      len_in = len_ff;
      seq_in = seq_ff;
      stamp_in = stamp_ff;
      run_in = run_ff;
      hdr_in = hdr_ff;
      rcv_in = rcv_ff;
      fwd = 1'b0;

      if (pos_ff == 11'd0) begin
         if (pkt_type != cfg.data_type_code && pkt_type != cfg.ack_type_code &&
             pkt_type != cfg.nack_type_code) begin
            err_in = ST_BAD_TYPE;
         end else if (win > cfg.max_window) begin
            err_in = ST_BAD_WINDOW;
         end
      end

      // big-endian length
      if (is_data && (pos_ff == 11'd1 || pos_ff == 11'd2)) begin
         len_in = {len_ff[7:0], byte_v};
         if (pos_ff == 11'd2 && err_in == ST_OK &&
             (len_in > {6'd0, cfg.max_payload} || len_in > PAYLOAD_LIMIT_W)) begin
            err_in = ST_BAD_LENGTH;
         end
      end
      len = is_data ? len_in : 16'd0;
      len_ext = {1'b0, len};

      if (pos_ff == (is_data ? 11'd3 : 11'd1)) begin
         seq_in = byte_v;
      end

      // timestamp, first byte lowest
      idx = is_data ? pos_ff[1:0] : pos_ff[1:0] + 2'd2;
      if (pos_ff >= (is_data ? 11'd4 : 11'd2) && pos_ff < hend) begin
         stamp_in = stamp_ff | ({24'd0, byte_v} << {idx, 3'b000});
      end

      // one crc unit serves header and payload
      crc_src = (pos_ff == 11'd0) ? (byte_v & TR_CLEAR_MASK) : byte_v;
      crc_step = crc32_byte(run_ff, crc_src);
      q = pos_ff - hend - 11'd4;
      q_ext = {6'd0, q};

      if (pos_ff < hend) begin
         if (pos_ff == hend - 11'd1) begin
            hdr_in = ~crc_step;
            run_in = CRC_INIT;
         end else begin
            run_in = crc_step;
         end
      end else if (pos_ff < hend + 11'd4) begin
         rcv_in = {rcv_ff[23:0], byte_v};
         if (pos_ff == hend + 11'd3 && err_in == ST_OK && rcv_in != hdr_ff) begin
            err_in = ST_CRC_ERROR;
         end
      end else if (q_ext < len_ext) begin
         fwd = (err_in == ST_OK);
         run_in = crc_step;
      end else if (len != 16'd0 && !tr && q_ext < len_ext + 17'd4) begin
         rcv_in = {rcv_ff[23:0], byte_v};
         if (q_ext == len_ext + 17'd3 && err_in == ST_OK && rcv_in != ~run_ff) begin
            err_in = ST_CRC_ERROR;
         end
      end

      pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 11'd1;

      // summary
      n = {1'b0, pos_ff} + 12'd1;
      needed = {6'd0, hend} + 17'd4 + len_ext +
               ((len != 16'd0 && !tr) ? 17'd4 : 17'd0);
      if (n < 12'd7) begin
         st = ST_NO_HEADER;
      end else if (n < 12'd10) begin
         st = ST_SHORT;
      end else if (err_in != ST_OK) begin
         st = err_in;
      end else if ({5'd0, n} < needed) begin
         st = ST_SHORT;
      end else begin
         st = ST_OK;
      end
      if (is_data && n >= 12'd3) begin
         plen = (len > 16'd1023) ? 10'h3FF : len[9:0];
      end else begin
         plen = 10'd0;
      end

      res = '0;
      if (eod_v) begin
         res.kind = 1'b1;
         res.payload_byte = fwd ? byte_v : 8'd0;
         res.status = st;
         res.packet_type = pkt_type;
         res.truncated_flag = tr;
         res.window_size = win;
         res.decoded_length = plen;
         res.sequence_number = seq_in;
         res.time_stamp = stamp_in;
         res.header_checksum = hdr_in;
         // end of datagram clears the per-datagram state
         pos_in = 11'd0;
         fhb_in = 8'd0;
         len_in = 16'd0;
         seq_in = 8'd0;
         stamp_in = 32'd0;
         run_in = CRC_INIT;
         hdr_in = 32'd0;
         rcv_in = 32'd0;
         err_in = ST_OK;
      end else if (fwd) begin
         res.payload_byte = byte_v;
      end
      res_valid = in_valid_ff && (eod_v || fwd);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff <= 11'd0;
         fhb_ff <= 8'd0;
         len_ff <= 16'd0;
         seq_ff <= 8'd0;
         stamp_ff <= 32'd0;
         run_ff <= CRC_INIT;
         hdr_ff <= 32'd0;
         rcv_ff <= 32'd0;
         err_ff <= ST_OK;
      end else begin
         in_valid_ff <= accept;
         if (in_valid_ff) begin
            pos_ff <= pos_in;
            fhb_ff <= fhb_in;
            len_ff <= len_in;
            seq_ff <= seq_in;
            stamp_ff <= stamp_in;
            run_ff <= run_in;
            hdr_ff <= hdr_in;
            rcv_ff <= rcv_in;
            err_ff <= err_in;
         end
      end
   end

   // a forwarded payload item only leaves while no error is recorded
   a_fwd_clean: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_item_ff.end_of_datagram && res_valid) |-> err_ff == ST_OK)
      else $error("payload item forwarded after an error");

   a_eod_clears: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_item_ff.end_of_datagram) |=>
         (pos_ff == 11'd0 && run_ff == CRC_INIT && err_ff == ST_OK))
      else $error("datagram state not cleared after last byte");

   a_pos_moves: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_item_ff.end_of_datagram) |=> pos_ff != 11'd0)
      else $error("byte position did not advance");

endmodule

FILE: hdl/cdf_outq.sv
// ----------------------------------------------------------------------------
// cdf_outq
// Small result queue that decouples the result channel from the input side.
// ----------------------------------------------------------------------------
module cdf_outq (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic                push,
   input  cdf_pkg::result_type push_data,
   output logic                req_ready,
   cdf_rsp_if.source           rsp_ch
);
   import cdf_pkg::*;

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   result_type           entry_ff [QUEUE_DEPTH];
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [PTR_W-1:0]     tail_ff, tail_in;
   logic                 pop;
   result_type           head_data;

   assign pop = rsp_ch.valid && rsp_ch.ready;
   assign head_data = entry_ff[head_ff];

   // an item still in the input register has a slot reserved
   assign req_ready = ((CNT_W+1)'(count_ff) + (CNT_W+1)'(in_valid)) <
                      (CNT_W+1)'(QUEUE_DEPTH);

   assign rsp_ch.valid = (count_ff != '0);
   assign rsp_ch.kind = head_data.kind;
   assign rsp_ch.payload_byte = head_data.payload_byte;
   assign rsp_ch.status = head_data.status;
   assign rsp_ch.packet_type = head_data.packet_type;
   assign rsp_ch.truncated_flag = head_data.truncated_flag;
   assign rsp_ch.window_size = head_data.window_size;
   assign rsp_ch.decoded_length = head_data.decoded_length;
   assign rsp_ch.sequence_number = head_data.sequence_number;
   assign rsp_ch.time_stamp = head_data.time_stamp;
   assign rsp_ch.header_checksum = head_data.header_checksum;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
      end
      if (push) begin
         tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         count_ff <= count_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CNT_W'(QUEUE_DEPTH)) || pop)
      else $error("result queue overflow");

endmodule

FILE: tb/crc_checked_packet_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_packet_deframer_tb
// Regression for the datagram deframer. Datagrams are built with valid CRCs,
// then cut short, corrupted or padded. A cycle-free model of the parser
// predicts every forwarded payload byte and every end-of-datagram summary.
// ----------------------------------------------------------------------------
module crc_checked_packet_deframer_tb;
   import cdf_pkg::*;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;
   localparam int unsigned RANDOM_ITEMS = 720;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned DRAIN_LIMIT = 20000;
   localparam int unsigned MAX_PRINTED = 40;

   logic clock;
   logic reset;

   cdf_req_if req_ch ();
   cdf_rsp_if rsp_ch ();
   cdf_csr_if csr_ch ();

   crc_checked_packet_deframer uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // parser model state
   cfg_type     model_cfg;
   logic [10:0] dg_pos;
   logic [7:0]  dg_first;
   logic [15:0] dg_len;
   logic [7:0]  dg_seq;
   logic [31:0] dg_stamp;
   logic [31:0] dg_crc;
   logic [31:0] dg_hdr_crc;
   logic [31:0] dg_rx_crc;
   logic [2:0]  dg_err;

   result_type  predicted_out[$];
   logic [7:0]  frame[$];

   int unsigned mismatches = 0;
   int unsigned items_sent = 0;
   int unsigned hold_cycles = 0;
   bit          tx_quiet = 1'b0;
   bit          rx_quiet = 1'b0;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
         $display("mismatch at %0t ns: %s", $time, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] seen,
                              input logic [31:0] want);
      if (seen !== want) begin
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, seen, want));
      end
   endtask

   function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      int          k;
      r = c;
      for (k = 0; k < 8; k++) begin
         if (r[0] ^ b[k]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   function automatic int unsigned pick_gap(input bit quiet);
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 96) return $urandom_range(3, 8);
      return $urandom_range(12, 40);
   endfunction

   task automatic clear_datagram();
      dg_pos = '0;
      dg_first = '0;
      dg_len = '0;
      dg_seq = '0;
      dg_stamp = '0;
      dg_crc = CRC_INIT;
      dg_hdr_crc = '0;
      dg_rx_crc = '0;
      dg_err = ST_OK;
   endtask

   task automatic apply_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [9:0] v);
      case (idx)
         CFG_DATA_TYPE: model_cfg.data_type_code = v[1:0];
         CFG_ACK_TYPE: model_cfg.ack_type_code = v[1:0];
         CFG_NACK_TYPE: model_cfg.nack_type_code = v[1:0];
         CFG_MAX_WINDOW: model_cfg.max_window = v[4:0];
         CFG_MAX_PAYLOAD: model_cfg.max_payload = v;
         default: ;
      endcase
   endtask

   // one accepted byte through the parser model
   task automatic predict_deframe(input logic [7:0] b, input logic eod);
      int unsigned p, off, hend, len, q, n, needed;
      logic [1:0]  ptype;
      logic        tr;
      logic [4:0]  win;
      logic        is_data;
      logic        fwd;
      logic [2:0]  st;
      result_type  r;
      p = dg_pos;
      fwd = 1'b0;
      if (p == 0) dg_first = b;
      ptype = dg_first[7:6];
      tr = dg_first[5];
      win = dg_first[4:0];
      is_data = (ptype == model_cfg.data_type_code);
      off = is_data ? 2 : 0;
      hend = 6 + off;

      if (p == 0) begin
         if (ptype != model_cfg.data_type_code && ptype != model_cfg.ack_type_code &&
             ptype != model_cfg.nack_type_code) begin
            dg_err = ST_BAD_TYPE;
         end else if (win > model_cfg.max_window) begin
            dg_err = ST_BAD_WINDOW;
         end
      end
      if (is_data && (p == 1 || p == 2)) begin
         dg_len = {dg_len[7:0], b};
         if (p == 2 && dg_err == ST_OK &&
             (dg_len > model_cfg.max_payload || dg_len > PAYLOAD_LIMIT_W)) begin
            dg_err = ST_BAD_LENGTH;
         end
      end
      len = is_data ? dg_len : 0;
      if (p == 1 + off) dg_seq = b;
      if (p >= 2 + off && p < 6 + off) dg_stamp |= 32'(b) << (8 * (p - 2 - off));

      if (p < hend) begin
         dg_crc = crc_next(dg_crc, (p == 0) ? (b & TR_CLEAR_MASK) : b);
         if (p == hend - 1) begin
            dg_hdr_crc = ~dg_crc;
            dg_crc = CRC_INIT;
         end
      end else if (p < hend + 4) begin
         dg_rx_crc = {dg_rx_crc[23:0], b};
         if (p == hend + 3 && dg_err == ST_OK && dg_rx_crc != dg_hdr_crc) dg_err = ST_CRC_ERROR;
      end else begin
         q = p - (hend + 4);
         if (q < len) begin
            fwd = (dg_err == ST_OK);
            dg_crc = crc_next(dg_crc, b);
         end else if (len != 0 && !tr && q < len + 4) begin
            dg_rx_crc = {dg_rx_crc[23:0], b};
            if (q == len + 3 && dg_err == ST_OK && dg_rx_crc != ~dg_crc) dg_err = ST_CRC_ERROR;
         end
      end
      if (dg_pos != POS_MAX) dg_pos++;

      r = '0;
      if (eod) begin
         n = p + 1;
         needed = hend + 4 + len + ((len != 0 && !tr) ? 4 : 0);
         if (n < 7) st = ST_NO_HEADER;
         else if (n < 10) st = ST_SHORT;
         else if (dg_err != ST_OK) st = dg_err;
         else if (n < needed) st = ST_SHORT;
         else st = ST_OK;
         r.kind = KIND_SUMMARY;
         r.payload_byte = fwd ? b : 8'd0;
         r.status = st;
         r.packet_type = ptype;
         r.truncated_flag = tr;
         r.window_size = win;
         r.decoded_length = (is_data && n >= 3) ? ((len > 1023) ? 10'h3FF : 10'(len)) : 10'd0;
         r.sequence_number = dg_seq;
         r.time_stamp = dg_stamp;
         r.header_checksum = dg_hdr_crc;
         predicted_out.push_back(r);
         clear_datagram();
      end else if (fwd) begin
         r.kind = KIND_PAYLOAD;
         r.payload_byte = b;
         predicted_out.push_back(r);
      end
   endtask

   // results are compared in order against the model
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (predicted_out.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d status %0d",
                                      rsp_ch.kind, rsp_ch.status));
         end else begin
            want = predicted_out.pop_front();
            check_field("kind", rsp_ch.kind, want.kind);
            check_field("payload_byte", rsp_ch.payload_byte, want.payload_byte);
            check_field("status", rsp_ch.status, want.status);
            check_field("packet_type", rsp_ch.packet_type, want.packet_type);
            check_field("truncated_flag", rsp_ch.truncated_flag, want.truncated_flag);
            check_field("window_size", rsp_ch.window_size, want.window_size);
            check_field("decoded_length", rsp_ch.decoded_length, want.decoded_length);
            check_field("sequence_number", rsp_ch.sequence_number, want.sequence_number);
            check_field("time_stamp", rsp_ch.time_stamp, want.time_stamp);
            check_field("header_checksum", rsp_ch.header_checksum, want.header_checksum);
         end
      end
   end

   // result side pacing; a pending hold request in hold_cycles parks ready low before random pacing resumes
   initial begin
      int unsigned n;
      forever begin
         if (hold_cycles != 0) begin
            n = hold_cycles;
            hold_cycles = 0;
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            n = pick_gap(rx_quiet);
            if (n != 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eod);
      int unsigned gap;
      gap = pick_gap(tx_quiet);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.end_of_datagram <= eod;
      do @(posedge clock); while (!req_ch.ready);
      predict_deframe(b, eod);
      items_sent++;
   endtask

   task automatic send_frame();
      int unsigned i;
      for (i = 0; i < frame.size(); i++) begin
         send_byte(frame[i], i == frame.size() - 1);
      end
   endtask

   // datagram with a valid header crc under the current type codes; payload crc only when the body matches the length
   task automatic build_frame(input logic [1:0] ptype, input logic tr, input logic [4:0] win,
                              input logic [15:0] len_field, input int unsigned body_len);
      logic [31:0] c;
      logic [31:0] stamp;
      logic [7:0]  b;
      logic        is_data;
      int unsigned i;
      is_data = (ptype == model_cfg.data_type_code);
      frame.delete();
      frame.push_back({ptype, tr, win});
      if (is_data) begin
         frame.push_back(len_field[15:8]);
         frame.push_back(len_field[7:0]);
      end
      frame.push_back(8'($urandom));
      stamp = $urandom;
      for (i = 0; i < 4; i++) frame.push_back(stamp[8*i +: 8]);
      c = CRC_INIT;
      for (i = 0; i < frame.size(); i++) begin
         c = crc_next(c, (i == 0) ? (frame[i] & TR_CLEAR_MASK) : frame[i]);
      end
      c = ~c;
      for (i = 0; i < 4; i++) frame.push_back(c[31 - 8*i -: 8]);
      c = CRC_INIT;
      for (i = 0; i < body_len; i++) begin
         b = 8'($urandom);
         frame.push_back(b);
         c = crc_next(c, b);
      end
      if (is_data && len_field != 0 && !tr && body_len == len_field) begin
         c = ~c;
         for (i = 0; i < 4; i++) frame.push_back(c[31 - 8*i -: 8]);
      end
   endtask

   task automatic wait_idle();
      int unsigned k;
      req_ch.valid <= 1'b0;
      k = 0;
      while (predicted_out.size() != 0 && k < DRAIN_LIMIT) begin
         @(posedge clock);
         k++;
      end
      if (predicted_out.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", predicted_out.size()));
         predicted_out.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [9:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= v;
      do @(posedge clock); while (!csr_ch.ready);
      apply_reg(idx, v);
   endtask

   // unused high bits of the narrow registers get random junk
   task automatic program_config(input logic [1:0] d, a, nk, input logic [4:0] w,
                                 input logic [9:0] mp);
      wait_idle();
      csr_write(CFG_DATA_TYPE, {8'($urandom), d});
      csr_write(CFG_ACK_TYPE, {8'($urandom), a});
      csr_write(CFG_NACK_TYPE, {8'($urandom), nk});
      csr_write(CFG_MAX_WINDOW, {5'($urandom), w});
      csr_write(CFG_MAX_PAYLOAD, mp);
      csr_write(CSR_INDEX_W'($urandom_range(int'(CFG_MAX_PAYLOAD) + 1, 7)), 10'($urandom));
      csr_ch.valid <= 1'b0;
   endtask

   task automatic test_basic_frames();
      build_frame(2'd2, 1'b0, 5'd4, 16'd0, 0);
      send_frame();
      build_frame(2'd1, 1'b0, 5'd0, 16'd0, 0);
      send_frame();
      build_frame(2'd1, 1'b0, 5'd9, 16'd5, 5);
      send_frame();
      // truncation bit set: no payload crc
      build_frame(2'd1, 1'b1, 5'd3, 16'd3, 3);
      send_frame();
      build_frame(2'd3, 1'b1, 5'd31, 16'd0, 0);
      send_frame();
      frame.delete();
      repeat (12) frame.push_back(8'hFF);
      send_frame();
      frame.delete();
      repeat (12) frame.push_back(8'h00);
      send_frame();
   endtask

   task automatic test_short_frames();
      int unsigned cuts[8] = '{1, 2, 3, 6, 7, 9, 14, 18};
      int unsigned i;
      for (i = 0; i < 8; i++) begin
         build_frame(2'd1, 1'b0, 5'd2, 16'd4, 4);
         frame = frame[0:cuts[i]-1];
         send_frame();
      end
   endtask

   task automatic test_error_frames();
      build_frame(2'd2, 1'b0, 5'd4, 16'd0, 0);
      frame[7] ^= 8'h01;
      send_frame();
      build_frame(2'd1, 1'b0, 5'd4, 16'd5, 5);
      frame[frame.size() - 1] ^= 8'h80;
      send_frame();
      build_frame(2'd1, 1'b0, 5'd4, 16'd513, 3);
      send_frame();
      build_frame(2'd1, 1'b0, 5'd4, 16'hFFFF, 2);
      send_frame();
      // trailing bytes past the payload crc
      build_frame(2'd1, 1'b0, 5'd4, 16'd2, 2);
      repeat (3) frame.push_back(8'($urandom));
      send_frame();
   endtask

   task automatic test_config_extremes();
      program_config(2'd0, 2'd0, 2'd0, 5'd0, 10'd0);
      build_frame(2'd0, 1'b0, 5'd0, 16'd0, 0);
      send_frame();
      build_frame(2'd0, 1'b0, 5'd1, 16'd0, 0);
      send_frame();
      build_frame(2'd0, 1'b0, 5'd0, 16'd1, 1);
      send_frame();
      build_frame(2'd1, 1'b0, 5'd0, 16'd0, 0);
      send_frame();

      program_config(2'd3, 2'd3, 2'd3, 5'd31, 10'h3FF);
      build_frame(2'd3, 1'b0, 5'd31, 16'd513, 2);
      send_frame();
      build_frame(2'd3, 1'b0, 5'd31, 16'd6, 6);
      send_frame();
      build_frame(2'd2, 1'b0, 5'd5, 16'd0, 0);
      send_frame();

      program_config(2'd2, 2'd0, 2'd0, 5'd10, 10'd40);
      build_frame(2'd0, 1'b0, 5'd10, 16'd0, 0);
      send_frame();
      build_frame(2'd0, 1'b0, 5'd11, 16'd0, 0);
      send_frame();
      // bad type wins over bad window
      build_frame(2'd1, 1'b0, 5'd20, 16'd0, 0);
      send_frame();
      build_frame(2'd2, 1'b0, 5'd3, 16'd40, 40);
      send_frame();
      build_frame(2'd2, 1'b0, 5'd3, 16'd41, 3);
      send_frame();
   endtask

   task automatic test_back_pressure();
      program_config(2'd1, 2'd2, 2'd3, 5'd31, 10'd512);
      tx_quiet = 1'b1;
      rx_quiet = 1'b1;
      hold_cycles = HOLD_CYCLES;
      // largest payload while the result side is held off
      build_frame(2'd1, 1'b0, 5'd7, 16'd512, 512);
      send_frame();
      build_frame(2'd2, 1'b0, 5'd1, 16'd0, 0);
      send_frame();
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   task automatic random_frame();
      logic [1:0]  ptype;
      logic        tr;
      logic [4:0]  win;
      logic [15:0] len;
      int unsigned body, pick, cut, k;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         frame.delete();
         repeat ($urandom_range(1, 14)) frame.push_back(8'($urandom));
         return;
      end
      case ($urandom_range(0, 9))
         0: ptype = 2'($urandom);
         1: ptype = model_cfg.ack_type_code;
         2: ptype = model_cfg.nack_type_code;
         default: ptype = model_cfg.data_type_code;
      endcase
      tr = ($urandom_range(0, 4) == 0);
      win = ($urandom_range(0, 7) == 0) ? 5'($urandom)
                                        : 5'($urandom_range(0, model_cfg.max_window));
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         len = 16'($urandom);
         body = $urandom_range(0, 6);
      end else if (pick == 1) begin
         len = 16'(model_cfg.max_payload) + 16'($urandom_range(0, 1));
         body = (len <= 48) ? len : $urandom_range(0, 4);
      end else begin
         len = 16'($urandom_range(0, 24));
         body = len;
      end
      if (ptype != model_cfg.data_type_code) body = 0;
      build_frame(ptype, tr, win, len, body);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         cut = $urandom_range(1, frame.size());
         frame = frame[0:cut-1];
      end else if (pick < 20) begin
         k = $urandom_range(0, frame.size() - 1);
         frame[k] ^= 8'(1 << $urandom_range(0, 7));
      end else if (pick < 26) begin
         repeat ($urandom_range(1, 5)) frame.push_back(8'($urandom));
      end
   endtask

   task automatic test_random_traffic();
      int unsigned phase, start;
      logic [1:0]  d;
      for (phase = 0; phase < 4; phase++) begin
         if (phase == 0) begin
            program_config(2'd1, 2'd2, 2'd3, 5'd31, 10'd512);
         end else begin
            d = 2'($urandom);
            program_config(d, ($urandom_range(0, 3) == 0) ? d : 2'($urandom), 2'($urandom),
                           ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'd31,
                           ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 30))
                                                       : 10'($urandom));
         end
         start = items_sent;
         while (items_sent - start < RANDOM_ITEMS / 4) begin
            tx_quiet = ($urandom_range(0, 9) == 0);
            rx_quiet = ($urandom_range(0, 9) == 0);
            random_frame();
            send_frame();
         end
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.end_of_datagram <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.data <= '0;
      model_cfg = '{data_type_code: 2'd1, ack_type_code: 2'd2, nack_type_code: 2'd3,
                    max_window: 5'd31, max_payload: 10'd512};
      clear_datagram();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_basic_frames();
      test_short_frames();
      test_error_frames();
      test_config_extremes();
      test_back_pressure();
      test_random_traffic();

      wait_idle();
      if (mismatches == 0) begin
         $display("crc_checked_packet_deframer regression: pass");
      end else begin
         $display("crc_checked_packet_deframer regression: fail");
      end
      $finish;
   end

   initial begin
      #6000000;
      $display("crc_checked_packet_deframer regression: fail");
      $finish;
   end

endmodule
